>>> src/wsf_pkg.sv
package wsf_pkg;

   // Identifiers at or above this value are reserved and refused
   localparam logic [15:0] FIRST_RESERVED_ID = 16'hFF00;
   // Upper bound on an accepted body, on top of the programmable limit
   localparam int unsigned BODY_LIMIT = 65535;
   // Identifier travels as the first two payload bytes
   localparam logic [16:0] ID_BYTES = 17'd2;

   // Register reset values
   localparam logic        MASK_FRAMES_RESET    = 1'b1;
   localparam logic [16:0] FRAGMENT_BYTES_RESET = 17'd0;
   localparam logic [15:0] MAX_BODY_BYTES_RESET = 16'd65535;
   localparam logic [31:0] SEED_RESET           = 32'd2463534242;

   // Configuration register indexes
   localparam logic [1:0] CSR_MASK_FRAMES    = 2'd0;
   localparam logic [1:0] CSR_FRAGMENT_BYTES = 2'd1;
   localparam logic [1:0] CSR_MAX_BODY_BYTES = 2'd2;
   localparam logic [1:0] CSR_MASK_SEED      = 2'd3;

   // Input item kinds
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BODY  = 1'b1;

   // Frame header codes
   localparam logic [3:0] OP_CONTINUATION = 4'h0;
   localparam logic [3:0] OP_BINARY       = 4'h2;
   localparam logic [6:0] LEN_SHORT_LIMIT = 7'd126;
   localparam logic [6:0] LEN_CODE_16     = 7'd126;
   localparam logic [6:0] LEN_CODE_64     = 7'd127;

   // Longest header: two fixed bytes, eight length bytes, four key bytes
   localparam int unsigned HDR_BYTES     = 14;
   localparam int unsigned HDR_BITS      = 8 * HDR_BYTES;
   localparam int unsigned HDR_CNT_BITS  = $clog2(HDR_BYTES + 1);

   // Queue between front and back end (depth is a power of two)
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ENT_REJECT,
      ENT_START,
      ENT_BODY
   } ent_kind_type;

   // One classified item: start carries id and size, body carries its byte in word[7:0]
   typedef struct packed {
      ent_kind_type kind;
      logic [15:0]  word;
      logic [15:0]  size;
   } entry_type;

   typedef struct packed {
      logic        mask_frames;
      logic [16:0] fragment_bytes;
      logic [15:0] max_body_bytes;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic [31:0] value;
   } seed_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MESSAGE,
      F_DROP
   } front_state_type;

   typedef enum logic {
      B_PAYLOAD,
      B_HEADER
   } back_state_type;

   // xorshift32 step: 13 left, 17 right, 5 left
   function automatic logic [31:0] next_key(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

>>> src/wsf_queue.sv
module wsf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  wsf_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               pop_valid,
   output wsf_pkg::entry_type pop_entry,
   input  logic               pop_ready
);
   import wsf_pkg::*;

   entry_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/wsf_front.sv
module wsf_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               command,
   input  logic [15:0]        message_id,
   input  logic [15:0]        body_size,
   input  logic [7:0]         data_byte,
   input  logic [15:0]        max_body_bytes,
   output logic               push_valid,
   output wsf_pkg::entry_type push_entry,
   input  logic               push_ready
);
   import wsf_pkg::*;

   front_state_type state_ff, state_in;
   logic [15:0]     count_ff, count_in;
   logic            accept;
   logic            refuse;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   assign refuse = (message_id >= FIRST_RESERVED_ID) || (body_size > max_body_bytes) ||
                   (32'(body_size) > BODY_LIMIT);

   // Classify each transfer and track the body bytes still owed
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_entry = '{kind: ENT_BODY, word: {8'h00, data_byte}, size: body_size};
      if (accept) begin
         if (command == CMD_START) begin
            push_valid      = 1'b1;
            push_entry.kind = refuse ? ENT_REJECT : ENT_START;
            push_entry.word = message_id;
            count_in        = body_size;
            if (body_size == '0) begin
               state_in = F_IDLE;
            end else begin
               state_in = refuse ? F_DROP : F_MESSAGE;
            end
         end else begin
            case (state_ff)
               F_MESSAGE: begin
                  push_valid = 1'b1;
                  count_in   = count_ff - 1'b1;
                  if (count_ff == 16'd1) begin
                     state_in = F_IDLE;
                  end
               end
               F_DROP: begin
                  count_in = count_ff - 1'b1;
                  if (count_ff == 16'd1) begin
                     state_in = F_IDLE;
                  end
               end
               default: begin
                  // stray body byte: drop
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/wsf_back.sv
module wsf_back (
   input  logic               clock,
   input  logic               reset,
   input  wsf_pkg::cfg_type   cfg,
   input  wsf_pkg::seed_type  seed,
   input  logic               pop_valid,
   input  wsf_pkg::entry_type pop_entry,
   output logic               pop_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);
   import wsf_pkg::*;

   back_state_type            state_ff, state_in;
   logic [16:0]               total_ff, total_in;
   logic [16:0]               pos_ff, pos_in;
   logic [16:0]               rem_ff, rem_in;
   logic [1:0]                off_ff, off_in;
   logic [31:0]               key_ff, key_in;
   logic [31:0]               gen_ff, gen_in;
   logic [HDR_BITS-1:0]       hdr_ff, hdr_in;
   logic [HDR_CNT_BITS-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic                      first_ff, first_in;
   logic                      init_ff, init_in;
   logic                      sub_ff, sub_in;

   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      out_fs_ff, out_fs_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_rej_ff, out_rej_in;

   logic                      out_free;
   logic                      fresh;
   logic [16:0]               eff_total, eff_pos, eff_rem;
   logic [16:0]               left, fsize;
   logic                      fin, mbit;
   logic [3:0]                opcode;
   logic [31:0]               new_key;
   logic [7:0]                b0;
   logic [HDR_BITS-1:0]       tmpl;
   logic [HDR_CNT_BITS-1:0]   tmpl_len;
   logic [7:0]                pay_byte, mask_byte;
   logic                      pay_last;

   assign out_free = !out_valid_ff || rsp_tready;

   // A start entry not yet opened restarts the message counters
   assign fresh     = pop_valid && (pop_entry.kind == ENT_START) && !init_ff;
   assign eff_total = fresh ? (17'(pop_entry.size) + ID_BYTES) : total_ff;
   assign eff_pos   = fresh ? '0 : pos_ff;
   assign eff_rem   = fresh ? '0 : rem_ff;

   // Size the next frame and build its header
   always_comb begin
      left    = eff_total - eff_pos;
      fsize   = (cfg.fragment_bytes == '0 || cfg.fragment_bytes > left) ? left
                : cfg.fragment_bytes;
      fin     = (fsize == left);
      opcode  = (eff_pos == '0) ? OP_BINARY : OP_CONTINUATION;
      mbit    = cfg.mask_frames;
      new_key = mbit ? next_key(gen_ff) : '0;
      b0      = {fin, 3'b000, opcode};
      if (fsize < 17'(LEN_SHORT_LIMIT)) begin
         tmpl     = {b0, mbit, fsize[6:0], new_key, 64'h0};
         tmpl_len = HDR_CNT_BITS'(2);
      end else if (!fsize[16]) begin
         tmpl     = {b0, mbit, LEN_CODE_16, fsize[15:0], new_key, 48'h0};
         tmpl_len = HDR_CNT_BITS'(4);
      end else begin
         tmpl     = {b0, mbit, LEN_CODE_64, 40'h0, 7'h00, fsize[16:0], new_key};
         tmpl_len = HDR_CNT_BITS'(10);
      end
      if (mbit) begin
         tmpl_len = tmpl_len + HDR_CNT_BITS'(4);
      end
   end

   // Pick the payload byte and its mask byte
   always_comb begin
      if (pop_entry.kind == ENT_START && sub_ff) begin
         pay_byte = pop_entry.word[15:8];
      end else begin
         pay_byte = pop_entry.word[7:0];
      end
      case (off_ff)
         2'd0:    mask_byte = key_ff[31:24];
         2'd1:    mask_byte = key_ff[23:16];
         2'd2:    mask_byte = key_ff[15:8];
         default: mask_byte = key_ff[7:0];
      endcase
      pay_last = ((pos_ff + 17'd1) == total_ff);
   end

   // Sequence headers and payload into the output register
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      off_in       = off_ff;
      key_in       = key_ff;
      gen_in       = gen_ff;
      hdr_in       = hdr_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      first_in     = first_ff;
      init_in      = init_ff;
      sub_in       = sub_ff;
      pop_ready    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_fs_in    = out_fs_ff;
      out_last_in  = out_last_ff;
      out_rej_in   = out_rej_ff;

      case (state_ff)
         B_PAYLOAD: begin
            if (pop_valid && out_free) begin
               if (pop_entry.kind == ENT_REJECT) begin
                  pop_ready    = 1'b1;
                  out_valid_in = 1'b1;
                  out_byte_in  = 8'h00;
                  out_fs_in    = 1'b0;
                  out_last_in  = 1'b1;
                  out_rej_in   = 1'b1;
               end else if (eff_rem == '0) begin
                  // open a frame: latch header, key and frame length
                  total_in   = eff_total;
                  pos_in     = eff_pos;
                  rem_in     = fsize;
                  off_in     = '0;
                  key_in     = new_key;
                  gen_in     = mbit ? new_key : gen_ff;
                  hdr_in     = tmpl;
                  hdr_cnt_in = tmpl_len;
                  first_in   = 1'b1;
                  init_in    = 1'b1;
                  state_in   = B_HEADER;
               end else begin
                  out_valid_in = 1'b1;
                  out_byte_in  = pay_byte ^ mask_byte;
                  out_fs_in    = 1'b0;
                  out_last_in  = pay_last;
                  out_rej_in   = 1'b0;
                  pos_in       = pos_ff + 17'd1;
                  rem_in       = rem_ff - 17'd1;
                  off_in       = off_ff + 2'd1;
                  if (pop_entry.kind == ENT_START && !sub_ff) begin
                     sub_in = 1'b1;
                  end else begin
                     pop_ready = 1'b1;
                     sub_in    = 1'b0;
                     init_in   = 1'b0;
                  end
               end
            end
         end
         B_HEADER: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = hdr_ff[HDR_BITS-1 -: 8];
               out_fs_in    = first_ff;
               out_last_in  = 1'b0;
               out_rej_in   = 1'b0;
               first_in     = 1'b0;
               hdr_in       = hdr_ff << 8;
               hdr_cnt_in   = hdr_cnt_ff - 1'b1;
               if (hdr_cnt_ff == HDR_CNT_BITS'(1)) begin
                  state_in = B_PAYLOAD;
               end
            end
         end
         default: begin
            state_in = B_PAYLOAD;
         end
      endcase

      // Seed writes load the generator directly
      if (seed.load) begin
         gen_in = seed.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_PAYLOAD;
         total_ff     <= '0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         off_ff       <= '0;
         key_ff       <= '0;
         gen_ff       <= SEED_RESET;
         hdr_cnt_ff   <= '0;
         first_ff     <= 1'b0;
         init_ff      <= 1'b0;
         sub_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         off_ff       <= off_in;
         key_ff       <= key_in;
         gen_ff       <= gen_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         first_ff     <= first_in;
         init_ff      <= init_in;
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      out_byte_ff <= out_byte_in;
      out_fs_ff   <= out_fs_in;
      out_last_ff <= out_last_in;
      out_rej_ff  <= out_rej_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_rej_ff, out_fs_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/websocket_message_framer_top.sv
// Binary-frame encoder for the sending side of a WebSocket link.
// req channel: one transfer per item. tuser is the command (0 start, 1 body byte);
// a start carries message_id and body_size, and body bytes follow one per transfer.
// rsp channel: one transfer per frame-stream byte; tuser[0] marks the first header
// byte of a frame, tuser[1] a refused start, tlast the final byte of the message.
// csr channel: register writes by index (0 mask_frames, 1 fragment_bytes,
// 2 max_body_bytes, 3 mask_seed); always ready, write only while the block is idle.
// Throughput: one output byte per cycle from the back end while rsp is ready and the
// queue holds entries, except while a frame is opened: its header is built first, then
// its header bytes (2 to 14) are sent. A start item yields at least two payload bytes.
// A mid-frame body byte reaches rsp through the queue and the output register; the
// first header byte of a new frame passes the queue, the header build and that register.
// A four-entry queue between front end and back end lets req keep flowing while
// headers are sent; req_tready drops only when that queue is full.
// When rsp stalls the output register holds its byte, the back end waits and the
// queue fills, after which req is back-pressured. Nothing is lost.
// Reset (synchronous, active high) empties the queue, clears all message state and
// restores the register reset values, with the mask generator at its seed.
module websocket_message_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_id[15:0], body_size[31:16], data_byte[39:32]
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic [1:0]  rsp_tuser,   // frame_start[0], rejected[1]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import wsf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   seed_type  seed;
   logic      csr_write;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Update configuration registers on a csr transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MASK_FRAMES:    cfg_in.mask_frames    = csr_data[0];
            CSR_FRAGMENT_BYTES: cfg_in.fragment_bytes = csr_data[16:0];
            CSR_MAX_BODY_BYTES: cfg_in.max_body_bytes = csr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   assign seed.load  = csr_write && (csr_index == CSR_MASK_SEED);
   assign seed.value = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mask_frames    <= MASK_FRAMES_RESET;
         cfg_ff.fragment_bytes <= FRAGMENT_BYTES_RESET;
         cfg_ff.max_body_bytes <= MAX_BODY_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wsf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .command        (req_tuser),
      .message_id     (req_tdata[15:0]),
      .body_size      (req_tdata[31:16]),
      .data_byte      (req_tdata[39:32]),
      .max_body_bytes (cfg_ff.max_body_bytes),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .push_ready     (push_ready)
   );

   wsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   wsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .seed       (seed),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
